>>> hdl/linear_array_deque_unit_macros.svh
// ----------------------------------------------------------------------------
// linear_array_deque_unit_macros
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
// Each macro takes a label, a property expression and a message; the clock is clk
// and the check is off while arst_n is low.
`ifndef LINEAR_ARRAY_DEQUE_UNIT_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define LAD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define LAD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// Shared constants, codes and the controller command type for the linear
// array deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lad_pkg;

	// store geometry
	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	// pointer values
	localparam logic [IDX_W-1:0] IDX_MID  = IDX_W'(DEPTH / 2);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK         = 2'd0;
	localparam logic [ST_W-1:0] STAT_FRONT_FULL = 2'd1;
	localparam logic [ST_W-1:0] STAT_BACK_FULL  = 2'd2;
	localparam logic [ST_W-1:0] STAT_EMPTY      = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming beat
		logic exec;     // run the latched operation on store and pointers
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/lad_ctrl.sv
// ----------------------------------------------------------------------------
// lad_ctrl
// Sequencer: accepts a beat, runs its execute state, then presents the
// result for one cycle while already able to take the next beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output lad_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q == ST_EXEC);
	assign done   = (state_q == ST_RESP);
	assign accept = start && !busy;

	// commands
	always_comb begin
		cmd.capture = accept;
		cmd.exec    = (state_q == ST_EXEC);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = accept ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

`default_nettype wire

>>> hdl/lad_dp.sv
// ----------------------------------------------------------------------------
// lad_dp
// Datapath: operation latch, front and back pointers, element store with a
// registered read port, and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire lad_pkg::cmd_t                        cmd,
	input  wire logic        [lad_pkg::OP_W-1:0]      operation,
	input  wire logic signed [lad_pkg::DATA_W-1:0]    value,
	output logic signed      [lad_pkg::DATA_W-1:0]   read_value,
	output logic             [lad_pkg::ST_W-1:0]     status
);

	// latched beat
	logic        [lad_pkg::OP_W-1:0]   op_q;
	logic signed [lad_pkg::DATA_W-1:0] value_q;

	// pointers
	logic [lad_pkg::IDX_W-1:0] front_q;
	logic [lad_pkg::IDX_W-1:0] back_q;
	logic [lad_pkg::IDX_W-1:0] front_d;
	logic [lad_pkg::IDX_W-1:0] back_d;

	// store
	logic signed [lad_pkg::DATA_W-1:0] mem [lad_pkg::DEPTH];
	logic signed [lad_pkg::DATA_W-1:0] rd_data_q;
	logic        [lad_pkg::IDX_W-1:0]  wr_addr;
	logic        [lad_pkg::IDX_W-1:0]  rd_addr;
	logic                              wr_en;
	logic                              rd_hit;

	// result
	logic [lad_pkg::ST_W-1:0] stat_d;
	logic [lad_pkg::ST_W-1:0] status_q;
	logic                     hit_q;
	logic                     empty;

	// beat latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			value_q <= value;
		end
	end

	// operation decode
	assign empty = (front_q == back_q);

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		wr_en   = 1'b0;
		wr_addr = front_q;
		rd_addr = back_q;
		rd_hit  = 1'b0;
		stat_d  = lad_pkg::STAT_OK;
		case (op_q)
			lad_pkg::OP_PUSH_FRONT: begin
				if (front_q == '0) begin
					stat_d = lad_pkg::STAT_FRONT_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_q;
					front_d = front_q - 1'b1;
				end
			end
			lad_pkg::OP_PUSH_BACK: begin
				if (back_q == lad_pkg::IDX_LAST) begin
					stat_d = lad_pkg::STAT_BACK_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = back_q + 1'b1;
					back_d  = back_q + 1'b1;
				end
			end
			lad_pkg::OP_POP_FRONT: begin
				if (empty) begin
					stat_d = lad_pkg::STAT_EMPTY;
				end else begin
					rd_hit  = 1'b1;
					rd_addr = front_q + 1'b1;
					front_d = front_q + 1'b1;
				end
			end
			lad_pkg::OP_POP_BACK: begin
				if (empty) begin
					stat_d = lad_pkg::STAT_EMPTY;
				end else begin
					rd_hit  = 1'b1;
					rd_addr = back_q;
					back_d  = back_q - 1'b1;
				end
			end
			lad_pkg::OP_PEEK_FRONT: begin
				if (empty) begin
					stat_d = lad_pkg::STAT_EMPTY;
				end else begin
					rd_hit  = 1'b1;
					rd_addr = front_q + 1'b1;
				end
			end
			lad_pkg::OP_PEEK_BACK: begin
				if (empty) begin
					stat_d = lad_pkg::STAT_EMPTY;
				end else begin
					rd_hit  = 1'b1;
					rd_addr = back_q;
				end
			end
			default: begin
				// unused codes: no change, ok status
			end
		endcase
	end

	// element store, one write and one registered read per execute cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wr_en) mem[wr_addr] <= value_q;
			rd_data_q <= mem[rd_addr];
		end
	end

	// pointers and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= lad_pkg::IDX_MID;
			back_q   <= lad_pkg::IDX_MID;
			status_q <= lad_pkg::STAT_OK;
			hit_q    <= 1'b0;
		end else if (cmd.exec) begin
			front_q  <= front_d;
			back_q   <= back_d;
			status_q <= stat_d;
			hit_q    <= rd_hit;
		end
	end

	assign read_value = hit_q ? rd_data_q : '0;
	assign status     = status_q;

endmodule

`default_nettype wire

>>> hdl/linear_array_deque_unit.sv
// A beat accepted at one edge is executed in the next cycle; its result
// is on read_value/status with done high in the cycle after that.
// A new beat is not taken while busy (execute); start is taken again in the done cycle.
// The store read is registered, which sets the execute/result split.
// Reset (arst_n low) puts both pointers at DEPTH/2; store contents are undefined.
// The receiver cannot stall: done is high for exactly one cycle with each result.
// ----------------------------------------------------------------------------
// linear_array_deque_unit
// Non-circular double-ended queue over a store of DEPTH words with push,
// pop and peek at both ends and an error status per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_array_deque_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic        [lad_pkg::OP_W-1:0]      operation,
	input  wire logic signed [lad_pkg::DATA_W-1:0]    value,
	output logic                                      done,
	output logic signed      [lad_pkg::DATA_W-1:0]   read_value,
	output logic             [lad_pkg::ST_W-1:0]     status
);

	lad_pkg::cmd_t cmd;

	// sequencer
	lad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// store and pointers
	lad_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (operation),
		.value      (value),
		.read_value (read_value),
		.status     (status)
	);

endmodule

`default_nettype wire

>>> hdl/lad_checker.sv
// ----------------------------------------------------------------------------
// lad_checker
// Port-level timing checks for the deque, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_array_deque_unit_macros.svh"

module lad_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic signed [lad_pkg::DATA_W-1:0]   read_value,
	input wire logic        [lad_pkg::ST_W-1:0]     status
);

	// an accepted beat goes straight into its execute cycle
	`LAD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")

	// the execute cycle is always followed by its result cycle
	`LAD_ASSERT(a_busy_done, busy |=> (done && !busy), "execute cycle not followed by result")

	// no result without a preceding execute cycle
	`LAD_ASSERT(a_done_after_busy, !busy |=> !done, "result strobe without a beat")

	// errors on an empty queue return zero data
	`LAD_NEVER(a_empty_zero, done && (status == lad_pkg::STAT_EMPTY) && (read_value != '0),
		"empty status with nonzero data")

endmodule

bind linear_array_deque_unit lad_checker u_lad_checker (.*);

`default_nettype wire
